### rtl/sfa_pkg.sv
// Shared types and defaults for the segregated free-list allocator.
// Request and response structs, status codes and parameter defaults.
// No dependencies.
`default_nettype none

package sfa_pkg;

  localparam int unsigned MIN_BLOCK_DEF   = 8;
  localparam int unsigned CLASS_COUNT_DEF = 14;
  localparam int unsigned POOL_BYTES_DEF  = 65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [16:0] request_bytes;
    logic [15:0] block_address;
  } req_t;

  typedef struct packed {
    logic [15:0] granted_address;
    status_e     status;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/segregated_free_list_allocator.sv
// Top level of the segregated power-of-two free-list allocator.
// Uses sfa_pkg for the request/response structs and status codes.
//
// Usage:
//   A request (allocate or free) is taken at a rising edge with start_i high
//   and busy_o low. Its response appears on rsp_o for exactly one cycle,
//   marked by rsp_valid_o, once S_EXEC has registered the result in rsp_q.
//   The receiver cannot stall; a response is simply consumed in its cycle.
// Sequencing:
//   A request occupies the block through S_EXEC (head memory read, then
//   update), and an allocate that pops a free list also through S_LINK,
//   where the next-link memory read comes before the class head is written
//   back. No new request is taken until S_IDLE; busy_o is high while a
//   request is in flight.
// State:
//   Class heads live in a small synchronous memory with one valid bit per
//   class; next links live in a synchronous memory indexed by block number.
//   Reset empties every class list and clears the bump pointer at once; the
//   link memory needs no clearing pass.
`default_nettype none

module segregated_free_list_allocator #(
  parameter int unsigned MIN_BLOCK   = sfa_pkg::MIN_BLOCK_DEF,
  parameter int unsigned CLASS_COUNT = sfa_pkg::CLASS_COUNT_DEF,
  parameter int unsigned POOL_BYTES  = sfa_pkg::POOL_BYTES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire sfa_pkg::req_t req_i,
  output logic              rsp_valid_o,
  output sfa_pkg::rsp_t     rsp_o
);

  import sfa_pkg::*;

  localparam int unsigned LMB         = $clog2(MIN_BLOCK);
  localparam int unsigned BLOCK_COUNT = POOL_BYTES / MIN_BLOCK;
  localparam int unsigned BIW         = $clog2(BLOCK_COUNT);
  localparam int unsigned HW          = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned KIW         = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned LIMW        = LMB + CLASS_COUNT;
  localparam int unsigned CW          = (LIMW > 17) ? LIMW : 17;
  localparam int unsigned PW          = $clog2(POOL_BYTES + 1);
  localparam int unsigned SW          = ((LIMW > PW) ? LIMW : PW) + 1;
  localparam int unsigned FIW         = 16 - LMB;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_e;

  state_e state_q;

  // memories
  logic [HW-1:0] heads_mem [CLASS_COUNT];
  logic [HW-1:0] link_mem  [BLOCK_COUNT];
  logic [HW-1:0] head_rd_q;
  logic [HW-1:0] link_rd_q;
  logic [CLASS_COUNT-1:0] heads_vld_q;

  // captured request
  logic           kind_q;
  logic [KIW-1:0] cls_q;
  logic           null_q;
  logic           big_q;
  logic [FIW-1:0] fidx_q;
  logic           fidx_bad_q;

  logic [PW-1:0] bump_q, bump_d;
  logic          bump_we;
  logic          rsp_valid_q;
  rsp_t          rsp_q, rsp_d;

  // class decode of the incoming size
  logic [CW-1:0]  bytes_ext;
  logic [KIW-1:0] cls_d;
  logic           fits_d;
  logic [FIW-1:0] fidx_d;
  logic           accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    bytes_ext = CW'(req_i.request_bytes);
    cls_d     = '0;
    fits_d    = 1'b0;
    // keep the smallest class that holds the size
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if ((CW'(MIN_BLOCK) << c) >= bytes_ext) begin
        cls_d  = KIW'(c);
        fits_d = 1'b1;
      end
    end
  end

  assign fidx_d = req_i.block_address[15:LMB];

  // execute step
  logic [HW-1:0] head_val;
  logic [HW-1:0] pop_idx;
  logic          pop_bad;
  logic [LIMW-1:0] blk_size;
  logic [SW-1:0] bump_sum;
  logic          hd_we;
  logic [HW-1:0] hd_wdata;
  logic          lk_we;
  logic          pop;

  assign head_val = heads_vld_q[cls_q] ? head_rd_q : '0;
  assign pop_idx  = head_val - HW'(1);
  assign pop_bad  = 32'(pop_idx) >= BLOCK_COUNT;
  assign blk_size = LIMW'(MIN_BLOCK) << cls_q;
  assign bump_sum = SW'(bump_q) + SW'(blk_size);

  always_comb begin
    rsp_d    = '{granted_address: 16'd0, status: ST_OK};
    hd_we    = 1'b0;
    hd_wdata = link_rd_q;
    lk_we    = 1'b0;
    pop      = 1'b0;
    bump_we  = 1'b0;
    bump_d   = bump_q;
    case (state_q)
      S_EXEC: begin
        if (null_q) begin
          rsp_d.status = ST_NULL;
        end else if (big_q) begin
          rsp_d.status = ST_TOO_LARGE;
        end else if (kind_q == KIND_FREE) begin
          if (fidx_bad_q) begin
            rsp_d.status = ST_TOO_LARGE;
          end else begin
            lk_we    = 1'b1;
            hd_we    = 1'b1;
            hd_wdata = HW'(fidx_q) + HW'(1);
          end
        end else if (head_val != '0) begin
          if (pop_bad) begin
            rsp_d.status = ST_TOO_LARGE;
          end else begin
            pop = 1'b1;
            rsp_d.granted_address = 16'(32'(pop_idx) << LMB);
          end
        end else if (bump_sum > SW'(POOL_BYTES)) begin
          rsp_d.status = ST_EXHAUSTED;
        end else begin
          bump_we = 1'b1;
          bump_d  = PW'(bump_sum);
          rsp_d.granted_address = 16'(32'(bump_q));
        end
      end
      S_LINK: begin
        // write back the popped block's successor as the new head
        hd_we    = 1'b1;
        hd_wdata = link_rd_q;
      end
      default: begin
        hd_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      heads_mem[cls_q] <= hd_wdata;
    end
    head_rd_q <= heads_mem[cls_d];
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[BIW'(fidx_q)] <= head_val;
    end
    link_rd_q <= link_mem[BIW'(pop_idx)];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= req_i.kind;
      cls_q      <= cls_d;
      null_q     <= (req_i.request_bytes == 17'd0);
      big_q      <= !fits_d;
      fidx_q     <= fidx_d;
      fidx_bad_q <= 32'(fidx_d) >= BLOCK_COUNT;
    end
    if (state_q == S_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      bump_q      <= '0;
      heads_vld_q <= '0;
    end else begin
      rsp_valid_q <= (state_q == S_EXEC);
      if (bump_we) begin
        bump_q <= bump_d;
      end
      if (hd_we) begin
        heads_vld_q[cls_q] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= pop ? S_LINK : S_IDLE;
        end
        S_LINK: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

### rtl/sfa_checker.sv
// Port-level checker for the segregated free-list allocator, and its bind.
// Depends on sfa_pkg and on the top level segregated_free_list_allocator.
`default_nettype none

module sfa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          rsp_valid_o,
  input wire sfa_pkg::rsp_t rsp_o
);

  import sfa_pkg::*;

  // every taken request is answered on rsp_valid_o
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 rsp_valid_o)
    else $error("response missing after accepted request");

  // a response only follows a cycle in which the block was busy
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy_o))
    else $error("response without a request in flight");

  // one response per request
  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("repeated response");

  // failed requests grant no address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> rsp_o.granted_address == 16'd0)
    else $error("nonzero address on failed request");

endmodule

bind segregated_free_list_allocator sfa_checker u_sfa_checker (.*);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for segregated_free_list_allocator. Drives directed and random
// allocate/free requests and checks every response against its directed table entry or a
// built-in predictor of free lists and bump pointer. Depends on sfa_pkg and the DUT.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfa_pkg::*;

  localparam int unsigned MIN_BLOCK   = MIN_BLOCK_DEF;
  localparam int unsigned CLASS_COUNT = CLASS_COUNT_DEF;
  localparam int unsigned POOL_BYTES  = POOL_BYTES_DEF;
  localparam int unsigned BLOCK_COUNT = POOL_BYTES / MIN_BLOCK;
  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i = '0;
  logic  busy_o;
  logic  rsp_valid_o;
  rsp_t  rsp_o;

  always #10 clk_i = ~clk_i;

  segregated_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // Allocator image: list heads and links hold block number plus one, zero is empty.
  logic [13:0] list_head [CLASS_COUNT];
  logic [13:0] next_link [BLOCK_COUNT];
  logic [16:0] bump_ptr;

  rsp_t        pending_rsp [$];
  logic [15:0] held_addr [$];
  logic [16:0] held_bytes [$];

  int unsigned n_bumps, n_pops, n_exhausted, n_frees, n_null, n_too_large;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic int unsigned class_of(logic [16:0] bytes);
    int unsigned k;
    k = 0;
    while (k < CLASS_COUNT && (MIN_BLOCK << k) < bytes) k++;
    return k;
  endfunction

  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t        rsp;
    int unsigned k;
    int unsigned idx;
    int unsigned blk;
    rsp.granted_address = '0;
    rsp.status = ST_OK;
    if (r.request_bytes == '0) begin
      rsp.status = ST_NULL;
      n_null++;
      return rsp;
    end
    k = class_of(r.request_bytes);
    if (k >= CLASS_COUNT) begin
      rsp.status = ST_TOO_LARGE;
      n_too_large++;
      return rsp;
    end
    if (r.kind == KIND_ALLOC) begin
      if (list_head[k] != '0) begin
        idx = list_head[k] - 1;
        list_head[k] = next_link[idx];
        rsp.granted_address = 16'(idx * MIN_BLOCK);
        n_pops++;
      end else begin
        blk = MIN_BLOCK << k;
        if (bump_ptr + blk > POOL_BYTES) begin
          rsp.status = ST_EXHAUSTED;
          n_exhausted++;
        end else begin
          rsp.granted_address = 16'(bump_ptr);
          bump_ptr = 17'(bump_ptr + blk);
          n_bumps++;
        end
      end
    end else begin
      idx = r.block_address / MIN_BLOCK;
      if (idx >= BLOCK_COUNT) begin
        rsp.status = ST_TOO_LARGE;
        n_too_large++;
      end else begin
        next_link[idx] = list_head[k];
        list_head[k] = 14'(idx + 1);
        n_frees++;
      end
    end
    return rsp;
  endfunction

  function automatic void add_row(logic kind, int unsigned bytes, int unsigned addr, bit typed,
                                  int unsigned exp_addr, status_e exp_status);
    dir_row_t row;
    row.req.kind = kind;
    row.req.request_bytes = 17'(bytes);
    row.req.block_address = 16'(addr);
    row.typed = typed;
    row.rsp.granted_address = 16'(exp_addr);
    row.rsp.status = exp_status;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [16:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 17'($urandom_range(64, 1));
    if (roll < 92) return 17'($urandom_range(1024, 65));
    return 17'($urandom_range(65536, 1025));
  endfunction

  // Mostly allocations and frees of held blocks; the rest zero, oversize and stray frees.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    int unsigned slot;
    r.kind = KIND_ALLOC;
    r.request_bytes = pick_size();
    r.block_address = 16'($urandom);
    roll = $urandom_range(99);
    if (roll >= 45 && roll < 82 && held_addr.size() != 0) begin
      slot = $urandom_range(held_addr.size() - 1);
      r.kind = KIND_FREE;
      r.block_address = held_addr[slot];
      r.request_bytes = held_bytes[slot];
      held_addr.delete(slot);
      held_bytes.delete(slot);
    end else if (roll >= 82 && roll < 88) begin
      r.kind = 1'($urandom);
      r.request_bytes = '0;
    end else if (roll >= 88 && roll < 94) begin
      r.kind = 1'($urandom);
      r.request_bytes = 17'($urandom_range(131071, 65537));
    end else if (roll >= 94 && roll < 97) begin
      r.kind = KIND_FREE;
    end
    return r;
  endfunction

  task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp,
                       input int unsigned idle_pct);
    rsp_t got;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    got = allocate_or_free(r);
    pending_rsp.push_back(typed ? typed_rsp : got);
    if (r.kind == KIND_ALLOC && got.status == ST_OK) begin
      held_addr.push_back(got.granted_address);
      held_bytes.push_back(r.request_bytes);
    end
  endtask

  // Check responses in order and watch for a stalled block.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (pending_rsp.size() == 0) begin
          $error("response with no request outstanding: granted_address %h status %0d",
                 rsp_o.granted_address, rsp_o.status);
          mismatches++;
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (rsp_o.granted_address !== exp_rsp.granted_address) begin
            $error("granted_address: expected %h, actual %h",
                   exp_rsp.granted_address, rsp_o.granted_address);
            mismatches++;
          end
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_o.status);
            mismatches++;
          end
        end
      end
      if (rsp_valid_o || (start_i && !busy_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("segregated_free_list_allocator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned idle_pcts [4];
    int unsigned done;
    req_t        r;
    idle_pcts = '{0, 46, 0, 30};
    done = 0;
    for (int i = 0; i < CLASS_COUNT; i++) list_head[i] = '0;
    bump_ptr = '0;

    add_row(KIND_ALLOC, 0,      16'h0000, 1, 16'h0000, ST_NULL);
    add_row(KIND_FREE,  0,      16'hffff, 1, 16'h0000, ST_NULL);
    add_row(KIND_ALLOC, 65537,  16'h0000, 1, 16'h0000, ST_TOO_LARGE);
    add_row(KIND_FREE,  131071, 16'h1234, 1, 16'h0000, ST_TOO_LARGE);
    add_row(KIND_ALLOC, 1,      16'hffff, 1, 16'h0000, ST_OK);
    add_row(KIND_ALLOC, 8,      16'h0000, 1, 16'h0008, ST_OK);
    add_row(KIND_ALLOC, 9,      16'h0000, 1, 16'h0010, ST_OK);
    add_row(KIND_ALLOC, 65536,  16'h0000, 1, 16'h0000, ST_EXHAUSTED);
    add_row(KIND_FREE,  8,      16'h0000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 5,      16'h0000, 0, 0, ST_OK);
    // unaligned free at the top of the pool
    add_row(KIND_FREE,  1,      16'hffff, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 3,      16'h0000, 0, 0, ST_OK);
    add_row(KIND_FREE,  16,     16'h0010, 0, 0, ST_OK);
    // free with the wrong size lands in the class of the given size
    add_row(KIND_FREE,  9,      16'h0008, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 16,     16'h0000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 10,     16'h0000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 16,     16'h0000, 1, 16'h0020, ST_OK);
    add_row(KIND_ALLOC, 32768,  16'h0000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 32768,  16'h0000, 1, 16'h0000, ST_EXHAUSTED);
    add_row(KIND_ALLOC, 16384,  16'h0000, 0, 0, ST_OK);
    // double free of the same block leaves the top class cycling on it
    add_row(KIND_FREE,  65536,  16'h8000, 0, 0, ST_OK);
    add_row(KIND_FREE,  40000,  16'h8000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 65536,  16'h0000, 0, 0, ST_OK);
    add_row(KIND_ALLOC, 50000,  16'h0000, 0, 0, ST_OK);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, 0);

    while (done < RANDOM_REQUESTS) begin
      r = pick_request();
      issue(r, 1'b0, '0, idle_pcts[done * 4 / RANDOM_REQUESTS]);
      if (r.request_bytes != '0) done++;
    end

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d bump grants, %0d list pops, %0d pool exhausted, %0d frees,",
             n_bumps, n_pops, n_exhausted, n_frees);
    $display("  %0d zero-size and %0d oversize requests, with sender gaps in two of four phases",
             n_null, n_too_large);
    if (mismatches == 0) begin
      $display("segregated_free_list_allocator: match");
    end else begin
      $display("segregated_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sfa_pkg.sv
rtl/segregated_free_list_allocator.sv
rtl/sfa_checker.sv
dv/tb.sv
